>>> design/dssvf_pkg.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: shared package
// Formats, configuration register indexes, controller and datapath types, and
// the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package dssvf_pkg;

  // Sample format Q1.SFRAC, state format Q9.SFRAC, coefficients with
  // COEF_FRAC_BITS fraction bits.
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int STATE_BITS     = SAMPLE_BITS + 8;
  localparam int SFRAC          = SAMPLE_BITS - 1;

  // Coefficient register widths.
  localparam int FREQ_W  = 23;
  localparam int DAMP_W  = 24;
  localparam int DRIVE_W = 23;

  // Configuration port.
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = CFG_IDX_W'(2);

  localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(1048576);
  localparam logic [DAMP_W-1:0]  DAMP_RST  = DAMP_W'(0);
  localparam logic [DRIVE_W-1:0] DRIVE_RST = DRIVE_W'(2097152);

  // Multiplier sizing. The largest magnitude fed to the first operand is the
  // cube of the band state, 2^(3*(STATE_BITS-1) - 2*SFRAC).
  localparam int MAG_BITS  = 3 * (STATE_BITS - 1) - 2 * SFRAC + 1;
  localparam int LO_BITS   = MAG_BITS / 2;
  localparam int HI_BITS   = MAG_BITS - LO_BITS;
  localparam int BMAG_BITS = STATE_BITS;
  localparam int ACC_BITS  = MAG_BITS + BMAG_BITS;
  localparam int PROD_BITS = MAG_BITS + 2;
  localparam int WIDE_BITS = PROD_BITS + 2;
  localparam int AVG_BITS  = STATE_BITS + 2;

  localparam logic [ACC_BITS-1:0] RND_SF = ACC_BITS'(1) << (SFRAC - 1);
  localparam logic [ACC_BITS-1:0] RND_CF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic signed [AVG_BITS-1:0]    avg_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam state_t  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam state_t  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};

  // Products of one filter pass, in issue order.
  typedef enum logic [2:0] {
    OP_DAMP_BAND,
    OP_FREQ_BAND,
    OP_BAND_SQ,
    OP_SQ_BAND,
    OP_DRIVE_CUBE,
    OP_FREQ_HIGH
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_PASS,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_x;
    logic issue;
    logic apply;
    op_e  op;
    logic save_pass1;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_status_t;

  // Saturate a wide intermediate to the signed state range.
  function automatic state_t sat_state(input wide_t v);
    logic [WIDE_BITS-STATE_BITS:0] top;
    top = v[WIDE_BITS-1:STATE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[STATE_BITS-1:0];
    end
    return v[WIDE_BITS-1] ? STATE_MIN : STATE_MAX;
  endfunction

  // Halve a sum of two pass values, ties away from zero, then saturate to
  // the sample range. A floor shift already rounds negative ties away.
  function automatic sample_t half_sat(input avg_t s);
    avg_t                   t;
    logic [AVG_BITS-2:0]    h;
    logic [AVG_BITS-SAMPLE_BITS-1:0] top;
    t   = s + avg_t'({{(AVG_BITS-1){1'b0}}, ~s[AVG_BITS-1]});
    h   = t[AVG_BITS-1:1];
    top = h[AVG_BITS-2:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return h[SAMPLE_BITS-1:0];
    end
    return h[AVG_BITS-2] ? SAMPLE_MIN : SAMPLE_MAX;
  endfunction

endpackage

>>> design/dssvf_if.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: stream interfaces
// Valid/ready channels for the input sample and for the filter outputs.
// ----------------------------------------------------------------------------
interface dssvf_in_if;
  import dssvf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface dssvf_out_if;
  import dssvf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t low_out;
  sample_t high_out;
  sample_t band_out;
  sample_t peak_out;
  sample_t notch_out;

  modport source (output valid, output low_out, output high_out, output band_out,
                  output peak_out, output notch_out, input ready);
  modport sink   (input valid, input low_out, input high_out, input band_out,
                  input peak_out, input notch_out, output ready);
endinterface

>>> design/dssvf_mul.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: shared multiplier
// Signed product scaled back by SFRAC or COEF_FRAC_BITS bits, chosen per
// product, and rounded to nearest with ties away from zero. Four stages:
// magnitudes, two partial products, sum with rounding constant, shift and sign.
// ----------------------------------------------------------------------------
module dssvf_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dssvf_pkg::prod_t    a_i,
  input  dssvf_pkg::state_t   b_i,
  input  logic                sh_sfrac_i,
  output logic                done_o,
  output dssvf_pkg::prod_t    p_o
);
  import dssvf_pkg::*;

  logic [MAG_BITS-1:0]          amag_q;
  logic [BMAG_BITS-1:0]         bmag_q;
  logic                         neg_q;
  logic                         sh_q;
  logic [LO_BITS+BMAG_BITS-1:0] pp_lo_q;
  logic [HI_BITS+BMAG_BITS-1:0] pp_hi_q;
  logic [ACC_BITS-1:0]          acc_q;
  prod_t                        p_q;
  logic                         v0_q, v1_q, v2_q, v3_q;

  logic [MAG_BITS-1:0]  amag_d;
  logic [BMAG_BITS-1:0] bmag_d;
  logic [ACC_BITS-1:0]  acc_d;
  logic [ACC_BITS-1:0]  shifted;
  logic [PROD_BITS-1:0] mag;

  always_comb begin
    amag_d  = a_i[PROD_BITS-1] ? MAG_BITS'(-a_i) : MAG_BITS'(a_i);
    bmag_d  = b_i[STATE_BITS-1] ? BMAG_BITS'(-b_i) : BMAG_BITS'(b_i);
    acc_d   = ACC_BITS'(pp_lo_q) + (ACC_BITS'(pp_hi_q) << LO_BITS)
              + (sh_q ? RND_SF : RND_CF);
    shifted = sh_q ? (acc_q >> SFRAC) : (acc_q >> COEF_FRAC_BITS);
    mag     = shifted[PROD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      amag_q <= amag_d;
      bmag_q <= bmag_d;
      neg_q  <= a_i[PROD_BITS-1] ^ b_i[STATE_BITS-1];
      sh_q   <= sh_sfrac_i;
    end
    pp_lo_q <= amag_q[LO_BITS-1:0] * bmag_q;
    pp_hi_q <= amag_q[MAG_BITS-1:LO_BITS] * bmag_q;
    acc_q   <= acc_d;
    if (v2_q) begin
      p_q <= neg_q ? prod_t'(-mag) : prod_t'(mag);
    end
  end

  assign done_o = v3_q;
  assign p_o    = p_q;

endmodule

>>> design/dssvf_datapath.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: datapath
// Coefficient registers, filter state, operand selection for the shared
// multiplier, state updates with saturation, and the averaged output register.
// ----------------------------------------------------------------------------
module dssvf_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dssvf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dssvf_pkg::CFG_W-1:0]     cfg_data_i,
  input  dssvf_pkg::sample_t              sample_i,
  input  dssvf_pkg::dp_cmd_t              cmd_i,
  output dssvf_pkg::dp_status_t           status_o,
  output dssvf_pkg::sample_t              low_o,
  output dssvf_pkg::sample_t              high_o,
  output dssvf_pkg::sample_t              band_o,
  output dssvf_pkg::sample_t              peak_o,
  output dssvf_pkg::sample_t              notch_o
);
  import dssvf_pkg::*;

  logic [FREQ_W-1:0]  freq_q;
  logic [DAMP_W-1:0]  damp_q;
  logic [DRIVE_W-1:0] drive_q;

  state_t  low_q, low_d;
  state_t  band_q, band_d;
  state_t  notch_q, notch_d;
  state_t  high_q, high_d;
  prod_t   tmp_q, tmp_d;
  sample_t x_q;
  state_t  l1_q, h1_q, b1_q, n1_q;
  sample_t low_out_q, high_out_q, band_out_q, peak_out_q, notch_out_q;

  prod_t  mul_a;
  state_t mul_b;
  logic   mul_sh_sfrac;
  prod_t  mul_p;
  logic   mul_done;

  // Operand selection for the product being issued.
  always_comb begin
    mul_a        = prod_t'(signed'({1'b0, freq_q}));
    mul_b        = high_q;
    mul_sh_sfrac = 1'b0;
    case (cmd_i.op)
      OP_DAMP_BAND: begin
        mul_a = prod_t'(signed'({1'b0, damp_q}));
        mul_b = band_q;
      end
      OP_FREQ_BAND: begin
        mul_b = band_q;
      end
      OP_BAND_SQ: begin
        mul_a        = prod_t'(band_q);
        mul_b        = band_q;
        mul_sh_sfrac = 1'b1;
      end
      OP_SQ_BAND: begin
        mul_a        = tmp_q;
        mul_b        = band_q;
        mul_sh_sfrac = 1'b1;
      end
      OP_DRIVE_CUBE: begin
        mul_a = tmp_q;
        mul_b = state_t'(signed'({1'b0, drive_q}));
      end
      default: begin
        mul_b = high_q;
      end
    endcase
  end

  dssvf_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.issue),
    .a_i        (mul_a),
    .b_i        (mul_b),
    .sh_sfrac_i (mul_sh_sfrac),
    .done_o     (mul_done),
    .p_o        (mul_p)
  );

  assign status_o.mul_done = mul_done;

  // State updates. High is formed once notch and the new low are settled,
  // at the issue of the band square.
  always_comb begin
    low_d   = low_q;
    band_d  = band_q;
    notch_d = notch_q;
    high_d  = high_q;
    tmp_d   = tmp_q;
    if (cmd_i.issue && (cmd_i.op == OP_BAND_SQ)) begin
      high_d = sat_state(wide_t'(notch_q) - wide_t'(low_q));
    end
    if (cmd_i.apply) begin
      case (cmd_i.op)
        OP_DAMP_BAND:  notch_d = sat_state(wide_t'(x_q) - wide_t'(mul_p));
        OP_FREQ_BAND:  low_d   = sat_state(wide_t'(low_q) + wide_t'(mul_p));
        OP_BAND_SQ,
        OP_SQ_BAND,
        OP_DRIVE_CUBE: tmp_d   = mul_p;
        OP_FREQ_HIGH:  band_d  = sat_state(wide_t'(mul_p) + wide_t'(band_q)
                                           - wide_t'(tmp_q));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FREQ_RST;
      damp_q  <= DAMP_RST;
      drive_q <= DRIVE_RST;
      low_q   <= '0;
      band_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FREQ:  freq_q  <= cfg_data_i[FREQ_W-1:0];
          REG_DAMP:  damp_q  <= cfg_data_i[DAMP_W-1:0];
          REG_DRIVE: drive_q <= cfg_data_i[DRIVE_W-1:0];
          default: ;
        endcase
      end
      low_q  <= low_d;
      band_q <= band_d;
    end
  end

  always_ff @(posedge clk_i) begin
    notch_q <= notch_d;
    high_q  <= high_d;
    tmp_q   <= tmp_d;
    if (cmd_i.load_x) begin
      x_q <= sample_i;
    end
    if (cmd_i.save_pass1) begin
      l1_q <= low_q;
      h1_q <= high_q;
      b1_q <= band_q;
      n1_q <= notch_q;
    end
    if (cmd_i.load_out) begin
      low_out_q   <= half_sat(avg_t'(l1_q) + avg_t'(low_q));
      high_out_q  <= half_sat(avg_t'(h1_q) + avg_t'(high_q));
      band_out_q  <= half_sat(avg_t'(b1_q) + avg_t'(band_q));
      peak_out_q  <= half_sat(avg_t'(l1_q) - avg_t'(h1_q)
                              + avg_t'(low_q) - avg_t'(high_q));
      notch_out_q <= half_sat(avg_t'(n1_q) + avg_t'(notch_q));
    end
  end

  assign low_o   = low_out_q;
  assign high_o  = high_out_q;
  assign band_o  = band_out_q;
  assign peak_o  = peak_out_q;
  assign notch_o = notch_out_q;

endmodule

>>> design/dssvf_ctrl.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: controller
// Sequences the six products of each of the two filter passes through the
// shared multiplier and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module dssvf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dssvf_pkg::dp_status_t status_i,
  output dssvf_pkg::dp_cmd_t    cmd_o
);
  import dssvf_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic        pass_q, pass_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DAMP_BAND;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pass_d     = pass_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          pass_d       = 1'b0;
          op_d         = OP_DAMP_BAND;
          state_d      = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_ISSUE;
          case (op_q)
            OP_DAMP_BAND:  op_d = OP_FREQ_BAND;
            OP_FREQ_BAND:  op_d = OP_BAND_SQ;
            OP_BAND_SQ:    op_d = OP_SQ_BAND;
            OP_SQ_BAND:    op_d = OP_DRIVE_CUBE;
            OP_DRIVE_CUBE: op_d = OP_FREQ_HIGH;
            default:       state_d = pass_q ? ST_OUT : ST_PASS;
          endcase
        end
      end
      ST_PASS: begin
        cmd_o.save_pass1 = 1'b1;
        pass_d           = 1'b1;
        op_d             = OP_DAMP_BAND;
        state_d          = ST_ISSUE;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/double_sampled_state_variable_filter_top.sv
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: top level
// Chamberlin state variable filter run twice per sample with cubic band
// damping; low, high, band, peak and notch outputs averaged over both passes.
// ----------------------------------------------------------------------------
// Each input transfer carries one signed Q1.23 sample and produces exactly one
// output transfer with the five saturated Q1.23 responses. Before the block can
// take the next sample, the two filter passes need twelve products in all, and
// every product goes through one shared four-stage multiplier (magnitudes, two
// 24x32 partial products, rounding sum, shift and sign) after its own issue
// step; input, pass hand-over and output loading add one controller state each.
// The result sits in an output register, so the next sample is taken while
// the previous result still waits for its transfer; the block only stalls if
// a second result is ready before the first one has left. The frequency,
// damping and drive coefficients are written through the configuration port
// (index 0, 1 and 2; higher indexes are ignored) and should be changed only
// while no sample is in flight. Internal state is Q9.23 and saturates, so
// unstable coefficient settings stay bounded but are not otherwise guarded.
// ----------------------------------------------------------------------------
module double_sampled_state_variable_filter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dssvf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dssvf_pkg::CFG_W-1:0]     cfg_data_i,
  dssvf_in_if.sink                        in_i,
  dssvf_out_if.source                     out_o
);
  import dssvf_pkg::*;

  // Command and status between the sequencer and the arithmetic.
  dp_cmd_t    cmd;
  dp_status_t status;

  dssvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the coefficients, the filter state and the output
  // register that drives the result payload.
  dssvf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (in_i.sample_in),
    .cmd_i      (cmd),
    .status_o   (status),
    .low_o      (out_o.low_out),
    .high_o     (out_o.high_out),
    .band_o     (out_o.band_out),
    .peak_o     (out_o.peak_out),
    .notch_o    (out_o.notch_out)
  );

endmodule

>>> test/tb_double_sampled_state_variable_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-sampled state variable filter: testbench
// Sends audio samples over the input channel and checks each filter output
// transfer against a bit-exact fixed-point model of the two filter passes.
// The coefficients are reprogrammed between phases while the filter is idle.
// ----------------------------------------------------------------------------
module tb_double_sampled_state_variable_filter_top;
  import dssvf_pkg::*;

  // Rough size of the run.
  localparam int N_ITEMS     = 1550;
  localparam int CALM_ITEMS  = 250;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 70;

  // Documented upper ends of the coefficient ranges.
  localparam int unsigned FREQ_HI  = 5931642;
  localparam int unsigned DAMP_HI  = 8388608;
  localparam int unsigned DRIVE_HI = 4194304;

  // The configuration port has one index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef struct packed {
    sample_t low;
    sample_t high;
    sample_t band;
    sample_t peak;
    sample_t notch;
  } filter_resp_t;

  // Scoreboard with its own copy of the coefficients and the filter state.
  // Every accepted sample runs through both passes here and the averaged
  // outputs wait in order for the matching output transfer.
  class svf_scoreboard;
    logic [FREQ_W-1:0]  freq_coef;
    logic [DAMP_W-1:0]  damp_coef;
    logic [DRIVE_W-1:0] drive_coef;
    state_t             low_st;
    state_t             band_st;
    filter_resp_t       pending_responses[$];
    int                 err_count;

    function new();
      freq_coef  = FREQ_RST;
      damp_coef  = DAMP_RST;
      drive_coef = DRIVE_RST;
      low_st     = '0;
      band_st    = '0;
      err_count  = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_FREQ:  freq_coef  = data[FREQ_W-1:0];
        REG_DAMP:  damp_coef  = data[DAMP_W-1:0];
        REG_DRIVE: drive_coef = data[DRIVE_W-1:0];
        default: ;
      endcase
    endfunction

    // (a*b) / 2^sh, nearest with ties away from zero, magnitude capped at 2^60.
    function longint round_product(input longint a, input longint b, input int unsigned sh);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] prod;
      longint       res;
      ua   = (a < 0) ? -a : a;
      ub   = (b < 0) ? -b : b;
      prod = {64'b0, ua} * {64'b0, ub};
      prod = prod + (128'(1) << (sh - 1));
      prod = prod >> sh;
      if (prod > (128'(1) << 60)) begin
        prod = 128'(1) << 60;
      end
      res = longint'(prod[63:0]);
      return ((a < 0) != (b < 0)) ? -res : res;
    endfunction

    function longint clamp_bits(input longint v, input int unsigned bits);
      longint mx;
      longint mn;
      mx = (longint'(1) << (bits - 1)) - 1;
      mn = -mx - 1;
      if (v > mx) begin
        return mx;
      end
      if (v < mn) begin
        return mn;
      end
      return v;
    endfunction

    // Half of a two-pass sum, ties away from zero, clipped to the sample range.
    function sample_t average_out(input longint s);
      longint h;
      h = (s >= 0) ? (s + 1) / 2 : -((-s + 1) / 2);
      return sample_t'(clamp_bits(h, SAMPLE_BITS));
    endfunction

    function void filter_pass(input longint x, output longint notch, output longint high);
      longint f;
      longint b;
      longint lo;
      longint b2;
      longint b3;
      longint cube;
      f      = longint'(freq_coef);
      b      = longint'(band_st);
      notch  = clamp_bits(x - round_product(longint'(damp_coef), b, COEF_FRAC_BITS),
                          STATE_BITS);
      lo     = clamp_bits(longint'(low_st) + round_product(f, b, COEF_FRAC_BITS), STATE_BITS);
      low_st = state_t'(lo);
      high   = clamp_bits(notch - lo, STATE_BITS);
      // Cubic damping of the band state: drive * band^3.
      b2     = round_product(b, b, SFRAC);
      b3     = round_product(b2, b, SFRAC);
      cube   = round_product(longint'(drive_coef), b3, COEF_FRAC_BITS);
      band_st = state_t'(clamp_bits(round_product(f, high, COEF_FRAC_BITS) + b - cube,
                                    STATE_BITS));
    endfunction

    function void note_sample(input sample_t s);
      longint       x;
      longint       n1;
      longint       h1;
      longint       l1;
      longint       bd1;
      longint       n2;
      longint       h2;
      longint       l2;
      longint       bd2;
      filter_resp_t r;
      x = longint'(s);
      filter_pass(x, n1, h1);
      l1  = longint'(low_st);
      bd1 = longint'(band_st);
      filter_pass(x, n2, h2);
      l2  = longint'(low_st);
      bd2 = longint'(band_st);
      r.low   = average_out(l1 + l2);
      r.high  = average_out(h1 + h2);
      r.band  = average_out(bd1 + bd2);
      r.peak  = average_out((l1 - h1) + (l2 - h2));
      r.notch = average_out(n1 + n2);
      pending_responses.push_back(r);
    endfunction

    function void compare_field(input string name, input sample_t want, input sample_t got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        err_count++;
      end
    endfunction

    function void check_response(input filter_resp_t got);
      filter_resp_t want;
      if (pending_responses.size() == 0) begin
        $error("filter output transfer with no sample outstanding");
        err_count++;
        return;
      end
      want = pending_responses.pop_front();
      compare_field("low_out", want.low, got.low);
      compare_field("high_out", want.high, got.high);
      compare_field("band_out", want.band, got.band);
      compare_field("peak_out", want.peak, got.peak);
      compare_field("notch_out", want.notch, got.notch);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  dssvf_in_if  in_bus ();
  dssvf_out_if out_bus ();

  svf_scoreboard sb = new();

  // Random idling on both channels; switched off for the last stretch.
  bit idle_enabled = 1'b1;
  int samples_sent = 0;

  double_sampled_state_variable_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Transfers are observed at the clock edge, before any of this edge's
  // updates land, so the monitor sees exactly what the filter sampled.
  always @(posedge clk_i) begin : transfer_monitor
    filter_resp_t seen;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_sample(in_bus.sample_in);
      end
      if (out_bus.valid && out_bus.ready) begin
        seen.low   = out_bus.low_out;
        seen.high  = out_bus.high_out;
        seen.band  = out_bus.band_out;
        seen.peak  = out_bus.peak_out;
        seen.notch = out_bus.notch_out;
        sb.check_response(seen);
      end
    end
  end

  // Output side back-pressure: ready drops for random bursts, and a new burst
  // can start as soon as one ends. The bursts exercise the output hold and, in
  // rare cases where they add up to more than one computation, also hold up the input.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 4);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one sample and holds it until the filter takes it. An optional
  // gap made of one or more short bursts comes first; long gaps let valid rise at
  // any point of the computation of the previous sample.
  task automatic send_sample(input sample_t s);
    int bursts;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      bursts = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 14) : 1;
      in_bus.valid <= 1'b0;
      repeat (bursts) begin
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= s;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    samples_sent++;
  endtask

  // One register write; the caller lowers the write enable after a series.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Coefficients change only once the last result has left the block. The
  // first wait lets the monitor log a sample taken at the current edge. The
  // unused index is written with random data each time; it must not disturb
  // any coefficient.
  task automatic program_filter(input logic [CFG_W-1:0] freq, input logic [CFG_W-1:0] damp,
                                input logic [CFG_W-1:0] drive);
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_coef(REG_FREQ, freq);
    write_coef(REG_UNUSED, CFG_W'($urandom));
    write_coef(REG_DAMP, damp);
    write_coef(REG_DRIVE, drive);
    cfg_we_i <= 1'b0;
  endtask

  // Zero, the documented upper end, any 24-bit pattern (above range values are
  // written unchanged; each register keeps only its own width), or a value from zero up to a typical one.
  function automatic logic [CFG_W-1:0] pick_coef(input int unsigned hi,
                                                 input int unsigned typical);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(hi);
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, typical));
    endcase
  endfunction

  // Mostly full-scale noise, with quiet passages, clipped extremes, held
  // levels and inverted steps to drive the state towards saturation.
  function automatic sample_t next_sample(input sample_t prev);
    case ($urandom_range(0, 9))
      5, 6:    return sample_t'(int'($urandom_range(0, 131070)) - 65535);
      7:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      8:       return prev;
      9:       return ~prev;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    sample_t prev;
    int      phase_len;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_FREQ;
    cfg_data_i       <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;
    prev = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset coefficients: silence, full-scale steps of both signs, and the
    // smallest nonzero samples.
    send_sample('0);
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample('0);

    // Highest documented frequency with no damping at all: the loop is
    // unstable and only saturation keeps the state bounded.
    program_filter(CFG_W'(FREQ_HI), '0, '0);
    repeat (4) send_sample(SAMPLE_MAX);
    repeat (4) send_sample(SAMPLE_MIN);

    // All coefficient bits set, beyond every documented range. The top bit
    // of the frequency and drive data falls outside their registers.
    program_filter('1, '1, '1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // Random phases, each with its own coefficient set. The filter state
    // carries over from one phase to the next, as it does in the block.
    while (samples_sent < N_ITEMS) begin
      program_filter(pick_coef(FREQ_HI, 2097152), pick_coef(DAMP_HI, DAMP_HI),
                     pick_coef(DRIVE_HI, DRIVE_HI));
      phase_len = $urandom_range(20, 120);
      for (int i = 0; i < phase_len && samples_sent < N_ITEMS; i++) begin
        if (samples_sent >= N_ITEMS - CALM_ITEMS) begin
          idle_enabled = 1'b0;
        end
        prev = next_sample(prev);
        send_sample(prev);
      end
    end

    // Let every result come out, then allow one more computation time for
    // anything unexpected to show up.
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
